/* hdl/mwf_pkg.sv */
// shared types, codes and the compare helper for the matrix where filter
`timescale 1ns / 1ps

package mwf_pkg;

   // default sizes of the condition table
   localparam int CLAUSES_DEF = 4;
   localparam int CONDS_DEF   = 4;

   // clause slots covered by the extended mode and count vectors; the clause registers hold four
   localparam int MAX_CLAUSES = 8;

   // decoupling queue between front and back
   localparam int QUEUE_DEPTH = 4;

   // configuration port
   localparam int ADDR_W = 5;
   localparam int DATA_W = 32;

   localparam logic [2:0] REG_ROWS        = 3'd0;
   localparam logic [2:0] REG_COLS        = 3'd1;
   localparam logic [2:0] REG_QUERY_MODE  = 3'd2;
   localparam logic [2:0] REG_CLAUSE_CNT  = 3'd3;
   localparam logic [2:0] REG_CLAUSE_MODE = 3'd4;
   localparam logic [2:0] REG_COND_COUNTS = 3'd5;

   // comparison operators
   localparam logic [2:0] OP_LT = 3'd0;
   localparam logic [2:0] OP_GT = 3'd1;
   localparam logic [2:0] OP_EQ = 3'd2;
   localparam logic [2:0] OP_NE = 3'd3;
   localparam logic [2:0] OP_LE = 3'd4;
   localparam logic [2:0] OP_GE = 3'd5;

   // clause and top-level combine modes
   localparam logic [1:0] MODE_NONE = 2'd0;
   localparam logic [1:0] MODE_ALL  = 2'd1;
   localparam logic [1:0] MODE_ANY  = 2'd2;
   localparam logic [1:0] MODE_BAD  = 2'd3;

   // request and result codes
   localparam logic REQ_LOAD     = 1'b0;
   localparam logic REQ_ELEMENT  = 1'b1;
   localparam logic KIND_MATCH   = 1'b0;
   localparam logic KIND_SUMMARY = 1'b1;

   typedef struct packed {
      logic               mode;
      logic [1:0]         slot_clause;
      logic [1:0]         slot_cond;
      logic [2:0]         cond_op;
      logic signed [31:0] cond_ref;
      logic signed [31:0] element_value;
   } req_type;

   typedef struct packed {
      logic        kind;
      logic [15:0] row;
      logic [15:0] col;
      logic [31:0] match_count;
      logic        query_error;
      logic        last;
   } rsp_type;

   typedef struct packed {
      logic [15:0] matrix_rows;
      logic [15:0] matrix_cols;
      logic [1:0]  query_mode;
      logic [2:0]  clauses_used;
      logic [7:0]  clause_modes;
      logic [15:0] clause_cond_counts;
   } cfg_type;

   // one queue entry: what the back end has to emit for one element
   typedef struct packed {
      logic        hit;
      logic        fin;
      logic [15:0] row;
      logic [15:0] col;
      logic [31:0] count;
      logic        err;
   } entry_type;

   function automatic logic cond_test(input logic [2:0] op,
                                      input logic signed [31:0] a,
                                      input logic signed [31:0] b);
      logic res;
      unique case (op)
         OP_LT:   res = a < b;
         OP_GT:   res = a > b;
         OP_EQ:   res = a == b;
         OP_NE:   res = a != b;
         OP_LE:   res = a <= b;
         default: res = a >= b;
      endcase
      return res;
   endfunction

endpackage

/* hdl/mwf_csr.sv */
// configuration registers behind the apb-style port
`timescale 1ns / 1ps

module mwf_csr (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       psel,
   input  logic                       penable,
   input  logic                       pwrite,
   input  logic [mwf_pkg::ADDR_W-1:0] paddr,
   input  logic [mwf_pkg::DATA_W-1:0] pwdata,
   output logic [mwf_pkg::DATA_W-1:0] prdata,
   output logic                       pready,
   output mwf_pkg::cfg_type           cfg
);
   import mwf_pkg::*;

   cfg_type    cfg_ff, cfg_in;
   logic [2:0] reg_idx;
   logic       wr_en;

   assign reg_idx = paddr[4:2];
   assign wr_en   = psel && penable && pwrite;
   assign pready  = 1'b1;
   assign cfg     = cfg_ff;

   always_comb begin
      cfg_in = cfg_ff;
      if (wr_en) begin
         unique case (reg_idx)
            REG_ROWS:        cfg_in.matrix_rows        = pwdata[15:0];
            REG_COLS:        cfg_in.matrix_cols        = pwdata[15:0];
            REG_QUERY_MODE:  cfg_in.query_mode         = pwdata[1:0];
            REG_CLAUSE_CNT:  cfg_in.clauses_used       = pwdata[2:0];
            REG_CLAUSE_MODE: cfg_in.clause_modes       = pwdata[7:0];
            REG_COND_COUNTS: cfg_in.clause_cond_counts = pwdata[15:0];
            default:         cfg_in = cfg_ff;
         endcase
      end
   end

   always_comb begin
      unique case (reg_idx)
         REG_ROWS:        prdata = {16'b0, cfg_ff.matrix_rows};
         REG_COLS:        prdata = {16'b0, cfg_ff.matrix_cols};
         REG_QUERY_MODE:  prdata = {30'b0, cfg_ff.query_mode};
         REG_CLAUSE_CNT:  prdata = {29'b0, cfg_ff.clauses_used};
         REG_CLAUSE_MODE: prdata = {24'b0, cfg_ff.clause_modes};
         REG_COND_COUNTS: prdata = {16'b0, cfg_ff.clause_cond_counts};
         default:         prdata = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.matrix_rows        <= 16'd1;
         cfg_ff.matrix_cols        <= 16'd1;
         cfg_ff.query_mode         <= MODE_NONE;
         cfg_ff.clauses_used       <= 3'd0;
         cfg_ff.clause_modes       <= 8'd0;
         cfg_ff.clause_cond_counts <= 16'd0;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

endmodule

/* hdl/mwf_front.sv */
// front end: condition table, query evaluation and scan position tracking
`timescale 1ns / 1ps

module mwf_front #(
   parameter int CLAUSES = mwf_pkg::CLAUSES_DEF,
   parameter int CONDS   = mwf_pkg::CONDS_DEF
) (
   input  logic               clock,
   input  logic               reset,
   input  mwf_pkg::cfg_type   cfg,
   input  logic               req_accept,
   input  mwf_pkg::req_type   req_data,
   output logic               push,
   output mwf_pkg::entry_type entry
);
   import mwf_pkg::*;

   logic [2:0]         ops_ff  [CLAUSES][CONDS];
   logic signed [31:0] refs_ff [CLAUSES][CONDS];

   logic [15:0] row_ff, row_in;
   logic [15:0] col_ff, col_in;
   logic [31:0] count_ff, count_in;

   logic [2*MAX_CLAUSES-1:0] modes_ext;
   logic [4*MAX_CLAUSES-1:0] counts_ext;
   logic                     err;
   logic                     top;
   logic                     hit;
   logic                     col_end;
   logic                     row_end;
   logic                     is_elem;
   logic [31:0]              count_hit;

   // clauses past the register width read as mode none with no conditions
   assign modes_ext  = {{(2*MAX_CLAUSES-8){1'b0}}, cfg.clause_modes};
   assign counts_ext = {{(4*MAX_CLAUSES-16){1'b0}}, cfg.clause_cond_counts};

   always_comb begin : p_eval
      logic [1:0] m;
      logic [3:0] n;
      logic       use_c;
      logic       cl_all;
      logic       cl;
      logic       top_all;
      logic       r;
      r   = 1'b0;
      err = (cfg.clauses_used == 3'd0) || (int'(cfg.clauses_used) > CLAUSES) ||
            (cfg.query_mode == MODE_BAD);
      top_all = (cfg.query_mode == MODE_ALL);
      top     = top_all;
      for (int i = 0; i < CLAUSES; i++) begin
         m      = modes_ext[2*i +: 2];
         n      = counts_ext[4*i +: 4];
         use_c  = i < int'(cfg.clauses_used);
         cl_all = (m == MODE_ALL);
         cl     = cl_all;
         for (int j = 0; j < CONDS; j++) begin
            if (j < int'(n)) begin
               r  = cond_test(ops_ff[i][j], req_data.element_value, refs_ff[i][j]);
               cl = cl_all ? (cl & r) : (cl | r);
               if (use_c && (ops_ff[i][j] > OP_GE)) begin
                  err = 1'b1;
               end
            end
         end
         if (use_c) begin
            if (m == MODE_NONE || m == MODE_BAD || n == 4'd0 || int'(n) > CONDS) begin
               err = 1'b1;
            end
            top = top_all ? (top & cl) : (top | cl);
         end
      end
   end

   assign is_elem   = req_accept && (req_data.mode == REQ_ELEMENT);
   assign hit       = !err && top;
   assign col_end   = ({1'b0, col_ff} + 17'd1) >= {1'b0, cfg.matrix_cols};
   assign row_end   = ({1'b0, row_ff} + 17'd1) >= {1'b0, cfg.matrix_rows};
   assign count_hit = (hit && (count_ff != '1)) ? count_ff + 32'd1 : count_ff;

   always_comb begin
      row_in   = row_ff;
      col_in   = col_ff;
      count_in = count_ff;
      if (req_accept && (req_data.mode == REQ_LOAD)) begin
         row_in   = '0;
         col_in   = '0;
         count_in = '0;
      end else if (is_elem) begin
         count_in = count_hit;
         if (col_end) begin
            col_in = '0;
            if (row_end) begin
               row_in   = '0;
               count_in = '0;
            end else begin
               row_in = row_ff + 16'd1;
            end
         end else begin
            col_in = col_ff + 16'd1;
         end
      end
   end

   assign push        = is_elem && (hit || (col_end && row_end));
   assign entry.hit   = hit;
   assign entry.fin   = col_end && row_end;
   assign entry.row   = row_ff;
   assign entry.col   = col_ff;
   assign entry.count = count_hit;
   assign entry.err   = err;

   // condition table: loaded by slot, no reset
   always_ff @(posedge clock) begin
      for (int i = 0; i < CLAUSES; i++) begin
         for (int j = 0; j < CONDS; j++) begin
            if (req_accept && (req_data.mode == REQ_LOAD) &&
                int'(req_data.slot_clause) == i && int'(req_data.slot_cond) == j) begin
               ops_ff[i][j]  <= req_data.cond_op;
               refs_ff[i][j] <= req_data.cond_ref;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         row_ff   <= '0;
         col_ff   <= '0;
         count_ff <= '0;
      end else begin
         row_ff   <= row_in;
         col_ff   <= col_in;
         count_ff <= count_in;
      end
   end

endmodule

/* hdl/mwf_queue.sv */
// short fifo that decouples the front end from the result stage
`timescale 1ns / 1ps

module mwf_queue #(
   parameter int DEPTH = mwf_pkg::QUEUE_DEPTH
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               push,
   input  mwf_pkg::entry_type push_data,
   input  logic               pop,
   output mwf_pkg::entry_type head,
   output logic               empty,
   output logic               full
);
   import mwf_pkg::*;

   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);

   entry_type        mem_ff [DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;

   assign empty = (cnt_ff == '0);
   assign full  = (cnt_ff == CNT_W'(DEPTH));
   assign head  = mem_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      cnt_in    = cnt_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_ff + PTR_W'(1);
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_ff + PTR_W'(1);
      end
      if (push && !pop) begin
         cnt_in = cnt_ff + CNT_W'(1);
      end else if (pop && !push) begin
         cnt_in = cnt_ff - CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wr_ptr_ff] <= push_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         cnt_ff    <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         cnt_ff    <= cnt_in;
      end
   end

endmodule

/* hdl/mwf_back.sv */
// back end: turns queue entries into match and summary results
`timescale 1ns / 1ps

module mwf_back (
   input  logic               clock,
   input  logic               reset,
   input  mwf_pkg::entry_type head,
   input  logic               empty,
   output logic               pop,
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output mwf_pkg::rsp_type   rsp_data
);
   import mwf_pkg::*;

   logic    rsp_valid_ff, rsp_valid_in;
   rsp_type rsp_data_ff, rsp_data_in;
   logic    phase_ff, phase_in;
   logic    out_free;

   assign out_free  = !rsp_valid_ff || !rsp_stall;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   always_comb begin
      pop          = 1'b0;
      phase_in     = phase_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      rsp_data_in  = rsp_data_ff;
      if (out_free && !empty) begin
         rsp_valid_in = 1'b1;
         if (head.hit && !phase_ff) begin
            rsp_data_in.kind        = KIND_MATCH;
            rsp_data_in.row         = head.row;
            rsp_data_in.col         = head.col;
            rsp_data_in.match_count = '0;
            rsp_data_in.query_error = 1'b0;
            rsp_data_in.last        = !head.fin;
            // a match on the final element keeps the entry for its summary
            if (head.fin) begin
               phase_in = 1'b1;
            end else begin
               pop = 1'b1;
            end
         end else begin
            rsp_data_in.kind        = KIND_SUMMARY;
            rsp_data_in.row         = '0;
            rsp_data_in.col         = '0;
            rsp_data_in.match_count = head.count;
            rsp_data_in.query_error = head.err;
            rsp_data_in.last        = 1'b1;
            pop                     = 1'b1;
            phase_in                = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      rsp_data_ff <= rsp_data_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
         phase_ff     <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
         phase_ff     <= phase_in;
      end
   end

endmodule

/* hdl/matrix_where_filter.sv */
// top level of the matrix where filter: csr block, front end, queue, back end
// a result's entry is written into the queue, then registered in the back end
// throughput: one request per cycle while the queue is not full and one result
// per cycle while rsp_stall is low; a match on the final element precedes its summary
// request side stalls only while the four-entry queue is full
// synchronous active-high reset clears control state and scan position, not the table
`timescale 1ns / 1ps

module matrix_where_filter #(
   parameter int CLAUSES = mwf_pkg::CLAUSES_DEF,
   parameter int CONDS   = mwf_pkg::CONDS_DEF
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       req_valid,
   output logic                       req_stall,
   input  mwf_pkg::req_type           req_data,
   output logic                       rsp_valid,
   input  logic                       rsp_stall,
   output mwf_pkg::rsp_type           rsp_data,
   input  logic                       psel,
   input  logic                       penable,
   input  logic                       pwrite,
   input  logic [mwf_pkg::ADDR_W-1:0] paddr,
   input  logic [mwf_pkg::DATA_W-1:0] pwdata,
   output logic [mwf_pkg::DATA_W-1:0] prdata,
   output logic                       pready
);
   import mwf_pkg::*;

   cfg_type   cfg;
   entry_type push_data;
   entry_type head;
   logic      push;
   logic      pop;
   logic      empty;
   logic      full;
   logic      req_accept;

   assign req_stall  = full;
   assign req_accept = req_valid && !full;

   mwf_csr u_csr (
      .clock   (clock),
      .reset   (reset),
      .psel    (psel),
      .penable (penable),
      .pwrite  (pwrite),
      .paddr   (paddr),
      .pwdata  (pwdata),
      .prdata  (prdata),
      .pready  (pready),
      .cfg     (cfg)
   );

   mwf_front #(
      .CLAUSES (CLAUSES),
      .CONDS   (CONDS)
   ) u_front (
      .clock      (clock),
      .reset      (reset),
      .cfg        (cfg),
      .req_accept (req_accept),
      .req_data   (req_data),
      .push       (push),
      .entry      (push_data)
   );

   mwf_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_data (push_data),
      .pop       (pop),
      .head      (head),
      .empty     (empty),
      .full      (full)
   );

   mwf_back u_back (
      .clock     (clock),
      .reset     (reset),
      .head      (head),
      .empty     (empty),
      .pop       (pop),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

endmodule

/* hdl/mwf_checker.sv */
// port-level checks for the matrix where filter, bound to the top level
`timescale 1ns / 1ps

module mwf_checker (
   input logic             clock,
   input logic             reset,
   input logic             rsp_valid,
   input logic             rsp_stall,
   input mwf_pkg::rsp_type rsp_data
);
   import mwf_pkg::*;

   // a stalled result holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_data))
      else $error("result changed while stalled");

   // summary carries no position, match carries no count or error
   a_fields: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |->
         (rsp_data.kind == KIND_SUMMARY &&
          rsp_data.row == 16'd0 && rsp_data.col == 16'd0 && rsp_data.last) ||
         (rsp_data.kind == KIND_MATCH &&
          rsp_data.match_count == 32'd0 && !rsp_data.query_error))
      else $error("result fields inconsistent with kind");

   // a match that is not last is followed at once by its summary
   a_match_then_summary: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_stall && rsp_data.kind == KIND_MATCH && !rsp_data.last
      |=> rsp_valid && rsp_data.kind == KIND_SUMMARY)
      else $error("summary missing after final match");

   // no result appears the cycle after reset
   a_reset_quiet: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("result valid after reset");

endmodule

bind matrix_where_filter mwf_checker u_mwf_checker (.*);

/* tb/sv/matrix_where_filter_tb.sv */
// self-checking testbench for the matrix where filter with a built-in predictor
`timescale 1ns / 1ps

module matrix_where_filter_tb;
   import mwf_pkg::*;

   localparam int NCL = CLAUSES_DEF;
   localparam int NCD = CONDS_DEF;
   localparam logic signed [31:0] VAL_MIN = 32'sh80000000;
   localparam logic signed [31:0] VAL_MAX = 32'sh7fffffff;

   logic clock;
   logic reset = 1'b1;

   logic                req_valid = 1'b0;
   logic                req_stall;
   req_type             req_data = '0;
   logic                rsp_valid;
   logic                rsp_stall = 1'b0;
   rsp_type             rsp_data;
   logic                psel = 1'b0;
   logic                penable = 1'b0;
   logic                pwrite = 1'b0;
   logic [ADDR_W-1:0]   paddr = '0;
   logic [DATA_W-1:0]   pwdata = '0;
   logic [DATA_W-1:0]   prdata;
   logic                pready;

   matrix_where_filter uut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_stall(req_stall), .req_data(req_data),
      .rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .rsp_data(rsp_data),
      .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
      .pwdata(pwdata), .prdata(prdata), .pready(pready)
   );

   // predictor copy of the registers, condition table and scan position
   logic [15:0]        cfg_rows = 16'd1;
   logic [15:0]        cfg_cols = 16'd1;
   logic [1:0]         cfg_qmode = MODE_NONE;
   logic [2:0]         cfg_clauses = 3'd0;
   logic [7:0]         cfg_cmodes = 8'd0;
   logic [15:0]        cfg_ncond = 16'd0;
   logic [2:0]         tbl_op [NCL][NCD];
   logic signed [31:0] tbl_ref [NCL][NCD];
   logic [15:0]        scan_row = 16'd0;
   logic [15:0]        scan_col = 16'd0;
   logic [31:0]        hit_count = 32'd0;

   req_type req_backlog [$];
   rsp_type rsp_owed [$];
   rsp_type rsp_want;
   int      mismatches = 0;
   int      idle_odds = 0;
   int      gap_left = 0;
   int      stall_left = 0;

   initial begin
      clock = 1'b0;
      forever #6 clock = ~clock;
   end

   initial begin
      #5000000;
      $display("end of test: mismatches");
      $finish;
   end

   function automatic bit op_holds(logic [2:0] op, logic signed [31:0] v,
                                   logic signed [31:0] r);
      bit below;
      bit same;
      below = v < r;
      same  = v == r;
      case (op)
         OP_LT:   return below;
         OP_GT:   return !below && !same;
         OP_EQ:   return same;
         OP_NE:   return !same;
         OP_LE:   return below || same;
         default: return !below;
      endcase
   endfunction

   function automatic bit query_bad();
      int i;
      int j;
      int n;
      logic [1:0] m;
      if (cfg_clauses == 3'd0 || int'(cfg_clauses) > NCL) return 1'b1;
      if (cfg_qmode == MODE_BAD) return 1'b1;
      for (i = 0; i < int'(cfg_clauses); i++) begin
         m = cfg_cmodes[2*i +: 2];
         n = int'(cfg_ncond[4*i +: 4]);
         if (m == MODE_NONE || m == MODE_BAD) return 1'b1;
         if (n == 0 || n > NCD) return 1'b1;
         for (j = 0; j < n; j++)
            if (tbl_op[i][j] > OP_GE) return 1'b1;
      end
      return 1'b0;
   endfunction

   function automatic bit query_hit(logic signed [31:0] v);
      int i;
      int j;
      bit top_all;
      bit top;
      bit all;
      bit cl;
      bit r;
      top_all = (cfg_qmode == MODE_ALL);
      top = top_all;
      for (i = 0; i < int'(cfg_clauses); i++) begin
         all = (cfg_cmodes[2*i +: 2] == MODE_ALL);
         cl = all;
         for (j = 0; j < int'(cfg_ncond[4*i +: 4]); j++) begin
            r = op_holds(tbl_op[i][j], v, tbl_ref[i][j]);
            cl = all ? (cl && r) : (cl || r);
         end
         top = top_all ? (top && cl) : (top || cl);
      end
      return top;
   endfunction

   // update the predicted state for one accepted request, queue its results
   task automatic filter_predict(req_type q);
      bit bad;
      bit hit;
      bit col_end;
      bit fin;
      rsp_type m;
      if (q.mode == REQ_LOAD) begin
         tbl_op[q.slot_clause][q.slot_cond] = q.cond_op;
         tbl_ref[q.slot_clause][q.slot_cond] = q.cond_ref;
         scan_row = 16'd0;
         scan_col = 16'd0;
         hit_count = 32'd0;
         return;
      end
      bad = query_bad();
      hit = !bad && query_hit(q.element_value);
      // a zero dimension behaves as one, a shrunk one ends at the next element
      col_end = int'(scan_col) + 1 >= int'(cfg_cols);
      fin = col_end && (int'(scan_row) + 1 >= int'(cfg_rows));
      if (hit) begin
         m = '0;
         m.kind = KIND_MATCH;
         m.row = scan_row;
         m.col = scan_col;
         m.last = !fin;
         rsp_owed.push_back(m);
         if (hit_count != 32'hffffffff) hit_count++;
      end
      if (fin) begin
         m = '0;
         m.kind = KIND_SUMMARY;
         m.match_count = hit_count;
         m.query_error = bad;
         m.last = 1'b1;
         rsp_owed.push_back(m);
      end
      if (col_end) begin
         scan_col = 16'd0;
         if (fin) begin
            scan_row = 16'd0;
            hit_count = 32'd0;
         end else begin
            scan_row++;
         end
      end else begin
         scan_col++;
      end
   endtask

   task automatic check_field(string what, logic [31:0] want, logic [31:0] seen);
      if (seen !== want) begin
         $display("%0t: %s expected %0h actual %0h", $time, what, want, seen);
         mismatches++;
      end
   endtask

   // request driver
   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
         gap_left = 0;
      end else begin
         if (req_valid && !req_stall) filter_predict(req_data);
         if (!req_valid || !req_stall) begin
            if (gap_left > 0) begin
               req_valid <= 1'b0;
               gap_left--;
            end else if (idle_odds != 0 && req_backlog.size() != 0 &&
                         $urandom_range(1, idle_odds) == 1) begin
               req_valid <= 1'b0;
               gap_left = $urandom_range(0, 5);
            end else if (req_backlog.size() != 0) begin
               req_valid <= 1'b1;
               req_data <= req_backlog.pop_front();
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // result monitor and stall generator
   always @(posedge clock) begin
      if (reset) begin
         rsp_stall <= 1'b0;
         stall_left = 0;
      end else begin
         if (rsp_valid && !rsp_stall) begin
            if (rsp_owed.size() == 0) begin
               $display("%0t: unexpected result %h", $time, rsp_data);
               mismatches++;
            end else begin
               rsp_want = rsp_owed.pop_front();
               check_field("kind", 32'(rsp_want.kind), 32'(rsp_data.kind));
               check_field("row", 32'(rsp_want.row), 32'(rsp_data.row));
               check_field("col", 32'(rsp_want.col), 32'(rsp_data.col));
               check_field("match_count", rsp_want.match_count, rsp_data.match_count);
               check_field("query_error", 32'(rsp_want.query_error),
                           32'(rsp_data.query_error));
               check_field("last", 32'(rsp_want.last), 32'(rsp_data.last));
            end
         end
         if (stall_left > 0) begin
            rsp_stall <= 1'b1;
            stall_left--;
         end else if (idle_odds != 0 && $urandom_range(1, idle_odds) == 1) begin
            rsp_stall <= 1'b1;
            stall_left = $urandom_range(0, 5);
         end else begin
            rsp_stall <= 1'b0;
         end
      end
   end

   task automatic csr_write(logic [2:0] idx, logic [31:0] val);
      @(posedge clock);
      psel <= 1'b1;
      penable <= 1'b0;
      pwrite <= 1'b1;
      paddr <= {idx, 2'b00};
      pwdata <= val;
      @(posedge clock);
      penable <= 1'b1;
      @(posedge clock);
      psel <= 1'b0;
      penable <= 1'b0;
      pwrite <= 1'b0;
      case (idx)
         REG_ROWS:        cfg_rows = val[15:0];
         REG_COLS:        cfg_cols = val[15:0];
         REG_QUERY_MODE:  cfg_qmode = val[1:0];
         REG_CLAUSE_CNT:  cfg_clauses = val[2:0];
         REG_CLAUSE_MODE: cfg_cmodes = val[7:0];
         REG_COND_COUNTS: cfg_ncond = val[15:0];
         default: ;
      endcase
   endtask

   task automatic queue_load(logic [1:0] c, logic [1:0] d, logic [2:0] op,
                             logic signed [31:0] r);
      req_type q;
      q.mode = REQ_LOAD;
      q.slot_clause = c;
      q.slot_cond = d;
      q.cond_op = op;
      q.cond_ref = r;
      q.element_value = $urandom;
      req_backlog.push_back(q);
   endtask

   task automatic queue_element(logic signed [31:0] v);
      req_type q;
      q.mode = REQ_ELEMENT;
      q.slot_clause = 2'($urandom_range(0, 3));
      q.slot_cond = 2'($urandom_range(0, 3));
      q.cond_op = 3'($urandom_range(0, 7));
      q.cond_ref = $urandom;
      q.element_value = v;
      req_backlog.push_back(q);
   endtask

   // wait until every request is taken and every result seen, then let the
   // pipeline drain requests that produce nothing
   task automatic settle();
      do @(negedge clock);
      while (req_backlog.size() != 0 || req_valid || rsp_owed.size() != 0);
      repeat (8) @(posedge clock);
   endtask

   function automatic logic signed [31:0] pick_value();
      case ($urandom_range(0, 5))
         0: return $urandom;
         1: begin
            case ($urandom_range(0, 3))
               0: return VAL_MIN;
               1: return VAL_MAX;
               2: return 32'sd0;
               default: return -32'sd1;
            endcase
         end
         // near a reference so that equality and boundary cases come up
         default: return tbl_ref[$urandom_range(0, NCL-1)][$urandom_range(0, NCD-1)]
                         + $signed($urandom_range(0, 2)) - 1;
      endcase
   endfunction

   task automatic pick_query();
      int i;
      logic [15:0] rows;
      logic [15:0] cols;
      logic [2:0]  ncl;
      logic [7:0]  modes;
      logic [15:0] counts;
      case ($urandom_range(0, 9))
         0: rows = 16'd0;
         1: rows = 16'($urandom_range(5, 40));
         default: rows = 16'($urandom_range(1, 4));
      endcase
      case ($urandom_range(0, 9))
         0: cols = 16'd0;
         1: cols = 16'($urandom_range(7, 30));
         default: cols = 16'($urandom_range(1, 6));
      endcase
      if ($urandom_range(0, 9) == 0) begin
         ncl = 3'($urandom_range(4, 7));
         if (ncl == 3'd4) ncl = 3'd0;
      end else begin
         ncl = 3'($urandom_range(1, 4));
      end
      for (i = 0; i < NCL; i++) begin
         if ($urandom_range(0, 11) == 0)
            modes[2*i +: 2] = $urandom_range(0, 1) ? MODE_BAD : MODE_NONE;
         else
            modes[2*i +: 2] = $urandom_range(0, 1) ? MODE_ALL : MODE_ANY;
         if ($urandom_range(0, 19) == 0)
            counts[4*i +: 4] = $urandom_range(0, 1) ? 4'd0 : 4'($urandom_range(5, 15));
         else
            counts[4*i +: 4] = 4'($urandom_range(1, 4));
      end
      csr_write(REG_ROWS, 32'(rows));
      csr_write(REG_COLS, 32'(cols));
      csr_write(REG_QUERY_MODE, ($urandom_range(0, 9) == 0) ? 32'(MODE_BAD)
                                 : 32'($urandom_range(0, 2)));
      csr_write(REG_CLAUSE_CNT, 32'(ncl));
      csr_write(REG_CLAUSE_MODE, 32'(modes));
      csr_write(REG_COND_COUNTS, 32'(counts));
   endtask

   initial begin
      int k;
      int phase;
      int load_odds;
      logic signed [31:0] seed_refs [16];
      logic [2:0] op;
      seed_refs = '{32'sd100, -32'sd100, 32'sd0, 32'sd5, VAL_MAX, VAL_MIN, -32'sd1,
                    32'sd1, 32'sd42, -32'sd42, 32'sd7, 32'sd0, 32'sd3, -32'sd3,
                    32'sd9, -32'sd9};
      repeat (7) @(posedge clock);
      reset <= 1'b0;
      @(negedge clock);
      idle_odds = 4;

      // fill the whole condition table; the last two conditions of the last clause get unknown operators
      for (k = 0; k < 16; k++) begin
         op = (k == 14) ? 3'd6 : (k == 15) ? 3'd7 : 3'(k % 6);
         queue_load(2'(k / 4), 2'(k % 4), op, seed_refs[k]);
      end
      // reset settings: no clauses, so every element is a one-element error matrix
      queue_element(VAL_MIN);
      queue_element(VAL_MAX);
      settle();

      // clause 0 all of (v < 100, v > -100), clause 1 any of four, top all
      csr_write(REG_ROWS, 32'd2);
      csr_write(REG_COLS, 32'd2);
      csr_write(REG_QUERY_MODE, 32'(MODE_ALL));
      csr_write(REG_CLAUSE_CNT, 32'd2);
      csr_write(REG_CLAUSE_MODE, 32'({4'd0, MODE_ANY, MODE_ALL}));
      csr_write(REG_COND_COUNTS, 32'h0000_0042);
      @(negedge clock);
      queue_element(32'sd0);
      queue_element(-32'sd1);
      queue_element(32'sd1);
      queue_element(VAL_MAX);
      queue_element(VAL_MIN);
      queue_element(32'sd100);
      settle();

      for (phase = 0; phase < 13; phase++) begin
         load_odds = 8;
         if (phase == 3) begin
            // widest matrix, elements only, so the scan stops mid-row
            csr_write(REG_ROWS, 32'h0000_ffff);
            csr_write(REG_COLS, 32'h0000_ffff);
            load_odds = 0;
         end else begin
            pick_query();
         end
         @(negedge clock);
         case ($urandom_range(0, 2))
            0: idle_odds = 0;
            1: idle_odds = 4;
            default: idle_odds = 12;
         endcase
         if (phase == 12) idle_odds = 0;
         for (k = 0; k < 48; k++) begin
            if (load_odds != 0 && $urandom_range(1, load_odds) == 1) begin
               case ($urandom_range(0, 3))
                  0, 1: seed_refs[0] = $signed($urandom_range(0, 20)) - 10;
                  2: seed_refs[0] = $urandom;
                  default: seed_refs[0] = $urandom_range(0, 1) ? VAL_MAX : VAL_MIN;
               endcase
               op = ($urandom_range(0, 15) == 0) ? 3'($urandom_range(6, 7))
                                                : 3'($urandom_range(0, 5));
               queue_load(2'($urandom_range(0, 3)), 2'($urandom_range(0, 3)), op,
                          seed_refs[0]);
            end else begin
               queue_element(pick_value());
            end
         end
         settle();
      end

      if (mismatches == 0 && rsp_owed.size() == 0)
         $display("end of test: clean");
      else
         $display("end of test: mismatches");
      $finish;
   end

endmodule
